>>> rtl/assert_macros.svh
// Assertion macros for the checker file of the texel decoder.
// Depends on nothing; every macro takes clock and active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/t4x4_pkg.sv
// Shared types, codes and color functions of the 4x4 texture block decoder.
// Used by the front, queue, back and top-level files; depends on nothing.
package t4x4_pkg;

    // Port widths
    localparam int S_TDATA_W = 96;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 40;
    localparam int FMT_W     = 2;

    // Block queue size
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Output formats
    localparam logic [FMT_W-1:0] FMT_RGB6A5 = 2'd0;
    localparam logic [FMT_W-1:0] FMT_RGBA8  = 2'd1;
    localparam logic [FMT_W-1:0] FMT_BGRA8  = 2'd2;

    // Block modes
    localparam logic [1:0] MODE_CLEAR3 = 2'd0;
    localparam logic [1:0] MODE_AVG    = 2'd1;
    localparam logic [1:0] MODE_DIRECT = 2'd2;
    localparam logic [1:0] MODE_MIX    = 2'd3;

    // Resolved color: bit 15 opaque, RGB555 below
    localparam logic [15:0] COLOR_CLEAR = 16'h0000;

    localparam logic [3:0] LAST_TEXEL = 4'd15;

    typedef logic [15:0] color_t;

    typedef struct packed {
        color_t [3:0] colors;
        logic [31:0]  indices;
    } block_t;

    // Per-channel floor((a+b)/2), opaque
    function automatic color_t avg_color(logic [14:0] a, logic [14:0] b);
        logic [5:0]  s [3];
        color_t      res;
        for (int i = 0; i < 3; i++) begin
            s[i] = {1'b0, a[5*i +: 5]} + {1'b0, b[5*i +: 5]};
        end
        res = {1'b1, s[2][5:1], s[1][5:1], s[0][5:1]};
        return res;
    endfunction

    // Per-channel floor((5a+3b)/8), opaque
    function automatic color_t mix_color(logic [14:0] a, logic [14:0] b);
        logic [7:0] ea;
        logic [7:0] eb;
        logic [7:0] s [3];
        color_t     res;
        for (int i = 0; i < 3; i++) begin
            ea   = {3'b000, a[5*i +: 5]};
            eb   = {3'b000, b[5*i +: 5]};
            s[i] = (ea << 2) + ea + (eb << 1) + eb;
        end
        res = {1'b1, s[2][7:3], s[1][7:3], s[0][7:3]};
        return res;
    endfunction

    // Widen a 5-bit channel to 6 bits, zero stays zero
    function automatic logic [5:0] up6(logic [4:0] c5);
        return (c5 != 5'd0) ? {c5, 1'b1} : 6'd0;
    endfunction

    // Convert a resolved color to the selected pixel format
    function automatic logic [31:0] convert_color(color_t col, logic [FMT_W-1:0] fmt);
        logic [4:0]  r;
        logic [4:0]  g;
        logic [4:0]  b;
        logic [31:0] res;
        r = col[4:0];
        g = col[9:5];
        b = col[14:10];
        case (fmt)
            FMT_RGB6A5: begin
                res = {3'b000, (col[15] ? 5'h1F : 5'h00), 2'b00, up6(b),
                       2'b00, up6(g), 2'b00, up6(r)};
            end
            FMT_BGRA8: begin
                res = {(col[15] ? 8'hFF : 8'h00), r, 3'b000, g, 3'b000, b, 3'b000};
            end
            default: begin
                res = {(col[15] ? 8'hFF : 8'h00), b, 3'b000, g, 3'b000, r, 3'b000};
            end
        endcase
        return res;
    endfunction

endpackage

>>> rtl/t4x4_front.sv
// Front end: accepts a compressed block word, resolves its four colors by mode
// and holds the result in one stage register for the queue. Uses t4x4_pkg.
module t4x4_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [t4x4_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [t4x4_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           push_valid,
    input  logic                           push_ready,
    output t4x4_pkg::block_t               push_block
);

    logic               stage_valid_reg;
    logic               stage_valid_next;
    t4x4_pkg::block_t   stage_reg;
    t4x4_pkg::block_t   resolved;
    logic [14:0]        c0;
    logic [14:0]        c1;
    logic [14:0]        c2;
    logic [14:0]        c3;
    logic               accept;

    // Unpack the word
    assign c0 = s_tdata[46:32];
    assign c1 = s_tdata[61:47];
    assign c2 = s_tdata[76:62];
    assign c3 = s_tdata[91:77];

    // Resolve the palette by block mode
    always_comb begin
        resolved.indices   = s_tdata[31:0];
        resolved.colors[0] = {1'b1, c0};
        resolved.colors[1] = {1'b1, c1};
        case (s_tuser)
            t4x4_pkg::MODE_CLEAR3: begin
                resolved.colors[2] = {1'b1, c2};
                resolved.colors[3] = t4x4_pkg::COLOR_CLEAR;
            end
            t4x4_pkg::MODE_AVG: begin
                resolved.colors[2] = t4x4_pkg::avg_color(c0, c1);
                resolved.colors[3] = t4x4_pkg::COLOR_CLEAR;
            end
            t4x4_pkg::MODE_DIRECT: begin
                resolved.colors[2] = {1'b1, c2};
                resolved.colors[3] = {1'b1, c3};
            end
            default: begin
                resolved.colors[2] = t4x4_pkg::mix_color(c0, c1);
                resolved.colors[3] = t4x4_pkg::mix_color(c1, c0);
            end
        endcase
    end

    // Take a new word whenever the stage is empty or drains this cycle
    assign s_tready   = !stage_valid_reg || push_ready;
    assign accept     = s_tvalid && s_tready;
    assign push_valid = stage_valid_reg;
    assign push_block = stage_reg;

    always_comb begin
        if (accept) begin
            stage_valid_next = 1'b1;
        end else if (push_ready) begin
            stage_valid_next = 1'b0;
        end else begin
            stage_valid_next = stage_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
        end else begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    // Hold the resolved block
    always_ff @(posedge aclk) begin
        if (accept) begin
            stage_reg <= resolved;
        end
    end

endmodule

>>> rtl/t4x4_queue.sv
// Short queue of resolved blocks between the front and back ends.
// Uses t4x4_pkg for the block type and depth.
module t4x4_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  t4x4_pkg::block_t push_block,
    output logic             pop_valid,
    input  logic             pop,
    output t4x4_pkg::block_t pop_block
);

    t4x4_pkg::block_t                  entry_reg [t4x4_pkg::QUEUE_DEPTH];
    logic [t4x4_pkg::QUEUE_PTR_W-1:0]  wr_ptr_reg;
    logic [t4x4_pkg::QUEUE_PTR_W-1:0]  rd_ptr_reg;
    logic [t4x4_pkg::QUEUE_CNT_W-1:0]  count_reg;
    logic [t4x4_pkg::QUEUE_CNT_W-1:0]  count_next;
    logic                              do_push;
    logic                              do_pop;

    assign push_ready = (count_reg != t4x4_pkg::QUEUE_CNT_W'(t4x4_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_block  = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Advance pointers, wrapping at the depth
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == t4x4_pkg::QUEUE_PTR_W'(t4x4_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == t4x4_pkg::QUEUE_PTR_W'(t4x4_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    // Store the pushed block
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_block;
        end
    end

endmodule

>>> rtl/t4x4_back.sv
// Back end: walks the sixteen texels of the current block, converts each color
// and drives the output register. Uses t4x4_pkg.
module t4x4_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [t4x4_pkg::FMT_W-1:0]     out_format,
    input  logic                           pop_valid,
    output logic                           pop,
    input  t4x4_pkg::block_t               pop_block,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [t4x4_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tlast
);

    t4x4_pkg::block_t                  cur_reg;
    logic                              busy_reg;
    logic                              busy_next;
    logic [3:0]                        cnt_reg;
    logic                              m_valid_reg;
    logic                              m_valid_next;
    logic [t4x4_pkg::M_TDATA_W-1:0]    m_data_reg;
    logic                              m_last_reg;
    logic                              advance;
    logic                              block_done;
    logic [1:0]                        sel;
    logic [31:0]                       texel;

    // Emit a texel when the output register is free or being taken
    assign advance    = busy_reg && (!m_valid_reg || m_tready);
    assign block_done = advance && (cnt_reg == t4x4_pkg::LAST_TEXEL);
    assign pop        = pop_valid && (!busy_reg || block_done);

    assign sel   = cur_reg.indices[{cnt_reg, 1'b0} +: 2];
    assign texel = t4x4_pkg::convert_color(cur_reg.colors[sel], out_format);

    always_comb begin
        if (pop) begin
            busy_next = 1'b1;
        end else if (block_done) begin
            busy_next = 1'b0;
        end else begin
            busy_next = busy_reg;
        end
    end

    always_comb begin
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Control: busy flag, texel counter, output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
            if (pop) begin
                cnt_reg <= '0;
            end else if (advance) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // Load the next block and the output word
    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_reg <= pop_block;
        end
        if (advance) begin
            m_data_reg <= {4'b0000, cnt_reg[1:0], cnt_reg[3:2], texel};
            m_last_reg <= (cnt_reg == t4x4_pkg::LAST_TEXEL);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

>>> rtl/tex4x4_block_decoder.sv
// Top level of the 4x4 texture block decoder: format register, front end,
// block queue and back end. Uses t4x4_pkg, t4x4_front, t4x4_queue, t4x4_back.
//
// channel  dir  handshake          payload
// s_       in   s_tvalid/s_tready  s_tdata block word, s_tuser block mode
// m_       out  m_tvalid/m_tready  m_tdata texel, m_tlast sixteenth texel
// cfg_     in   cfg_valid/cfg_ready cfg_data out_format
//
// Each block yields sixteen texels, one per cycle from the back end's texel
// counter while m_tready is high; a queued next block follows without a gap.
// A block word passes the front stage, the queue and the block register in order.
// Front stage and a two-entry queue let the input keep taking words while
// the output stalls. Reset (aresetn low, synchronous) empties all stages and
// sets out_format to RGBA8. cfg_ready is always high.
module tex4x4_block_decoder (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [31:0] texel_indices, [46:32] palette_color0, [61:47] palette_color1,
    // [76:62] palette_color2, [91:77] palette_color3, [95:92] zero
    input  logic [t4x4_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] block_mode
    input  logic [t4x4_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [31:0] texel_color, [33:32] texel_row, [35:34] texel_col, [39:36] zero
    output logic [t4x4_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tlast,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [t4x4_pkg::FMT_W-1:0]     cfg_data
);

    logic [t4x4_pkg::FMT_W-1:0] out_format_reg;
    logic                       push_valid;
    logic                       push_ready;
    t4x4_pkg::block_t           push_block;
    logic                       pop_valid;
    logic                       pop;
    t4x4_pkg::block_t           pop_block;

    // Hold the output format
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_format_reg <= t4x4_pkg::FMT_RGBA8;
        end else if (cfg_valid && cfg_ready) begin
            out_format_reg <= cfg_data;
        end
    end

    t4x4_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_block (push_block)
    );

    t4x4_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_block (push_block),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_block  (pop_block)
    );

    t4x4_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .out_format (out_format_reg),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_block  (pop_block),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

>>> rtl/t4x4_checker.sv
// Port-level checker of the texel decoder, bound to the top level.
// Uses assert_macros.svh and t4x4_pkg.
`include "assert_macros.svh"

module t4x4_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [t4x4_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tlast
);

    logic [3:0] pos_reg;
    logic [2:0] pending_reg;
    logic       in_word;
    logic       out_word;
    logic       out_done;
    logic       pos_ok;
    logic       last_ok;
    logic       clear_word;
    logic       rgb_zero;
    logic       stalled;

    assign in_word  = s_tvalid && s_tready;
    assign out_word = m_tvalid && m_tready;
    assign out_done = out_word && m_tlast;

    // Compare the output word against the expected texel position
    assign pos_ok     = (m_tdata[33:32] == pos_reg[3:2]) && (m_tdata[35:34] == pos_reg[1:0]);
    assign last_ok    = (m_tlast == (pos_reg == t4x4_pkg::LAST_TEXEL));
    assign clear_word = m_tvalid && (m_tdata[31:24] == 8'h00);
    assign rgb_zero   = (m_tdata[23:0] == 24'h000000);
    assign stalled    = m_tvalid && !m_tready;

    // Track texel position and blocks in flight
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            pending_reg <= '0;
        end else begin
            if (out_word) begin
                pos_reg <= pos_reg + 1'b1;
            end
            if (in_word && !out_done) begin
                pending_reg <= pending_reg + 1'b1;
            end else if (out_done && !in_word) begin
                pending_reg <= pending_reg - 1'b1;
            end
        end
    end

    `ASSERT_IMPLIES(a_row_col_order, aclk, aresetn, out_word, pos_ok)
    `ASSERT_IMPLIES(a_last_on_sixteenth, aclk, aresetn, out_word, last_ok)
    `ASSERT_IMPLIES(a_no_texel_without_block, aclk, aresetn, m_tvalid, pending_reg != 3'd0)
    `ASSERT_IMPLIES(a_clear_texel_is_zero, aclk, aresetn, clear_word, rgb_zero)
    `ASSERT_NEXT(a_stall_holds, aclk, aresetn, stalled, m_tvalid && $stable({m_tlast, m_tdata}))

endmodule

bind tex4x4_block_decoder t4x4_checker u_t4x4_checker (.*);

>>> test/tb.sv
// Self-checking bench for tex4x4_block_decoder: drives compressed 4x4 blocks,
// predicts the sixteen texels of each in every output format, checks each word.
// Depends on t4x4_pkg and the decoder RTL.
module tb;

    localparam logic [t4x4_pkg::FMT_W-1:0] FMT_RESERVED = 2'd3;
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [31:0] color;
        logic [1:0]  row;
        logic [1:0]  col;
        logic        last;
    } texel_t;

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [t4x4_pkg::S_TDATA_W-1:0]   s_tdata = '0;
    logic [t4x4_pkg::S_TUSER_W-1:0]   s_tuser = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [t4x4_pkg::M_TDATA_W-1:0]   m_tdata;
    logic                             m_tlast;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [t4x4_pkg::FMT_W-1:0]       cfg_data = '0;

    // Texels still owed by the decoder, oldest first
    texel_t                     texels_due [$];
    logic [t4x4_pkg::FMT_W-1:0] fmt_now = t4x4_pkg::FMT_RGBA8;
    int                         n_bad = 0;
    int                         n_reported = 0;
    int                         idle_cycles = 0;
    int                         rx_hold = 0;
    int                         rx_stall = 0;
    bit                         idle_on = 1'b0;

    always #6 aclk = ~aclk;

    tex4x4_block_decoder u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Weighted per-channel blend of two RGB555 colors, result marked opaque
    function automatic logic [15:0] weigh(logic [14:0] a, logic [14:0] b,
                                          int wa, int wb, int sh);
        logic [15:0] res;
        int          sum;
        res = 16'h8000;
        for (int i = 0; i < 3; i++) begin
            sum = int'(a[5*i +: 5]) * wa + int'(b[5*i +: 5]) * wb;
            res[5*i +: 5] = 5'(sum >> sh);
        end
        return res;
    endfunction

    function automatic logic [31:0] wide6(logic [4:0] x);
        return (x == 5'd0) ? 32'd0 : 32'({x, 1'b1});
    endfunction

    // Convert a resolved color (bit 15 opaque) to the given pixel format
    function automatic logic [31:0] to_pixel(logic [15:0] c,
                                             logic [t4x4_pkg::FMT_W-1:0] fmt);
        logic [31:0] r;
        logic [31:0] g;
        logic [31:0] b;
        r = 32'(c[4:0]);
        g = 32'(c[9:5]);
        b = 32'(c[14:10]);
        if (fmt == t4x4_pkg::FMT_RGB6A5) begin
            return wide6(c[4:0]) | (wide6(c[9:5]) << 8) | (wide6(c[14:10]) << 16)
                   | (c[15] ? 32'h1F00_0000 : 32'h0);
        end else if (fmt == t4x4_pkg::FMT_BGRA8) begin
            return (b << 3) | (g << 11) | (r << 19) | (c[15] ? 32'hFF00_0000 : 32'h0);
        end
        return (r << 3) | (g << 11) | (b << 19) | (c[15] ? 32'hFF00_0000 : 32'h0);
    endfunction

    // Resolve the block palette and queue its sixteen texels in row order
    task automatic predict_block(logic [31:0] idx, logic [1:0] mode,
                                 logic [14:0] c0, logic [14:0] c1,
                                 logic [14:0] c2, logic [14:0] c3);
        logic [15:0] pal [4];
        texel_t      t;
        pal[0] = {1'b1, c0};
        pal[1] = {1'b1, c1};
        case (mode)
            t4x4_pkg::MODE_CLEAR3: begin
                pal[2] = {1'b1, c2};
                pal[3] = t4x4_pkg::COLOR_CLEAR;
            end
            t4x4_pkg::MODE_AVG: begin
                pal[2] = weigh(c0, c1, 1, 1, 1);
                pal[3] = t4x4_pkg::COLOR_CLEAR;
            end
            t4x4_pkg::MODE_DIRECT: begin
                pal[2] = {1'b1, c2};
                pal[3] = {1'b1, c3};
            end
            default: begin
                pal[2] = weigh(c0, c1, 5, 3, 3);
                pal[3] = weigh(c0, c1, 3, 5, 3);
            end
        endcase
        for (int k = 0; k < 16; k++) begin
            t.color = to_pixel(pal[idx[2*k +: 2]], fmt_now);
            t.row   = 2'(k >> 2);
            t.col   = 2'(k);
            t.last  = (k == 15);
            texels_due.push_back(t);
        end
    endtask

    // Offer one block word, after an optional idle burst; leave valid high
    task automatic drive_block(logic [31:0] idx, logic [1:0] mode,
                               logic [14:0] c0, logic [14:0] c1,
                               logic [14:0] c2, logic [14:0] c3);
        int gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = {4'b0000, c3, c2, c1, c0, idx};
        s_tuser  = mode;
        do @(posedge aclk); while (!s_tready);
        predict_block(idx, mode, c0, c1, c2, c3);
    endtask

    function automatic logic [14:0] pick_color();
        logic [14:0] c;
        logic [4:0]  edges [4];
        edges = '{5'd0, 5'd1, 5'd30, 5'd31};
        c = 15'($urandom);
        // Favor channel extremes now and then
        if ($urandom_range(0, 3) == 0) begin
            for (int i = 0; i < 3; i++) begin
                c[5*i +: 5] = edges[$urandom_range(0, 3)];
            end
        end
        return c;
    endfunction

    task automatic drive_random_block();
        logic [31:0] idx;
        idx = $urandom;
        if ($urandom_range(0, 9) == 0) begin
            idx = {16{2'($urandom_range(0, 3))}};
        end
        drive_block(idx, 2'($urandom_range(0, 3)), pick_color(), pick_color(),
                    pick_color(), pick_color());
    endtask

    // Drop valid and hold until every owed texel has come back
    task automatic drain_texels();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (texels_due.size() != 0) @(posedge aclk);
    endtask

    task automatic write_format(logic [t4x4_pkg::FMT_W-1:0] fmt);
        drain_texels();
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data  = fmt;
        do @(posedge aclk); while (!cfg_ready);
        fmt_now = fmt;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Modes, palette extremes, rounding of the blends, every format
    task automatic test_directed();
        logic [t4x4_pkg::FMT_W-1:0] fmts [4];
        fmts = '{t4x4_pkg::FMT_RGB6A5, t4x4_pkg::FMT_BGRA8, FMT_RESERVED,
                 t4x4_pkg::FMT_RGBA8};
        // Reset format first, no write yet
        drive_block(32'hE4E4_E4E4, t4x4_pkg::MODE_CLEAR3,
                    15'h0000, 15'h7FFF, 15'h0421, 15'h5555);
        drive_block(32'hE4E4_E4E4, t4x4_pkg::MODE_AVG,
                    15'h7FFF, 15'h7FFF, 15'h1234, 15'h4321);
        drive_block(32'hE4E4_E4E4, t4x4_pkg::MODE_AVG,
                    15'h7FFF, 15'h0000, 15'h7FFF, 15'h7FFF);
        drive_block(32'h1B1B_1B1B, t4x4_pkg::MODE_AVG,
                    15'h0421, 15'h0000, 15'h0000, 15'h0000);
        drive_block(32'h1B1B_1B1B, t4x4_pkg::MODE_DIRECT,
                    15'h7C00, 15'h03E0, 15'h001F, 15'h7FFF);
        drive_block(32'hE4E4_E4E4, t4x4_pkg::MODE_MIX,
                    15'h7FFF, 15'h0000, 15'h0000, 15'h0000);
        drive_block(32'hE4E4_E4E4, t4x4_pkg::MODE_MIX,
                    15'h0000, 15'h7FFF, 15'h7FFF, 15'h7FFF);
        drive_block(32'hE4E4_E4E4, t4x4_pkg::MODE_MIX,
                    15'h7FFF, 15'h7FFF, 15'h0000, 15'h0000);
        drive_block(32'h1B1B_1B1B, t4x4_pkg::MODE_MIX,
                    15'h0421, 15'h0842, 15'h0000, 15'h0000);
        drive_block(32'h0000_0000, t4x4_pkg::MODE_DIRECT,
                    15'h0000, 15'h0000, 15'h0000, 15'h0000);
        drive_block(32'hFFFF_FFFF, t4x4_pkg::MODE_CLEAR3,
                    15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF);
        drive_block(32'hFFFF_FFFF, t4x4_pkg::MODE_DIRECT,
                    15'h0000, 15'h0000, 15'h0000, 15'h7FFF);
        // Walk every format, the reserved code too
        for (int f = 0; f < 4; f++) begin
            write_format(fmts[f]);
            drive_block(32'hE4E4_E4E4, t4x4_pkg::MODE_CLEAR3,
                        15'h0421, 15'h7FFF, 15'h0000, 15'h7FFF);
            drive_block(32'h1B1B_1B1B, t4x4_pkg::MODE_MIX,
                        pick_color(), pick_color(), 15'h0, 15'h0);
            drive_block(32'hE4E4_E4E4, t4x4_pkg::MODE_DIRECT,
                        15'h7C00, 15'h03E0, 15'h001F, 15'h0421);
        end
        drain_texels();
    endtask

    // Hold the output off so the decoder fills and stalls its input
    task automatic test_backpressure();
        idle_on = 1'b0;
        rx_hold = 300;
        repeat (12) drive_random_block();
        drain_texels();
    endtask

    // Random blocks over several formats, idling on, then a closing stretch without
    task automatic test_random();
        for (int p = 0; p < 4; p++) begin
            write_format(2'($urandom_range(0, 3)));
            idle_on = 1'b1;
            repeat (95) drive_random_block();
        end
        write_format(2'($urandom_range(0, 3)));
        idle_on = 1'b0;
        repeat (40) drive_random_block();
        drain_texels();
    endtask

    // Receiver: long hold-off on request, random stall bursts otherwise
    always @(negedge aclk) begin
        if (rx_hold > 0) begin
            m_tready = 1'b0;
            rx_hold  = rx_hold - 1;
        end else if (rx_stall > 0) begin
            m_tready = 1'b0;
            rx_stall = rx_stall - 1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            m_tready = 1'b0;
            rx_stall = $urandom_range(0, 2);
        end else begin
            m_tready = 1'b1;
        end
    end

    // Check each output word against the oldest owed texel
    always @(posedge aclk) begin : check_texels
        texel_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (texels_due.size() == 0) begin
                n_bad = n_bad + 1;
                if (n_reported < REPORT_MAX) begin
                    n_reported = n_reported + 1;
                    $display("unexpected texel: data %h last %b", m_tdata, m_tlast);
                end
            end else begin
                want = texels_due.pop_front();
                if (m_tdata[31:0] !== want.color || m_tdata[33:32] !== want.row ||
                    m_tdata[35:34] !== want.col || m_tlast !== want.last) begin
                    n_bad = n_bad + 1;
                    if (n_reported < REPORT_MAX) begin
                        n_reported = n_reported + 1;
                        $display("mismatch: want color %h row %0d col %0d last %0d",
                                 want.color, want.row, want.col, want.last);
                        $display("          got  color %h row %0d col %0d last %0d",
                                 m_tdata[31:0], m_tdata[33:32], m_tdata[35:34], m_tlast);
                    end
                end
            end
        end
    end

    // Watchdog: end the run when no word moves on any channel for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        repeat (3) @(negedge aclk);
        aresetn = 1'b1;
        test_directed();
        test_backpressure();
        test_random();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (n_bad == 0 && texels_due.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
